// File: rtl/bif_pkg.sv
package bif_pkg;

  localparam int CFG_W    = 10;
  localparam int RAD_W    = 2;
  localparam int CIDX_W   = 2;
  localparam int KIND_W   = 2;
  localparam int PIX_W    = 8;
  localparam int TIDX_W   = 8;
  localparam int TVAL_W   = 16;
  localparam int TAP_W    = 3;
  localparam int QUO_BITS = 9;
  localparam int PIPE_LAT = 3;
  localparam int RANGE_DEPTH = 256;

  localparam int DEF_MAX_WIDTH   = 512;
  localparam int DEF_MAX_HEIGHT  = 512;
  localparam int DEF_MAX_RADIUS  = 3;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RANGE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPATIAL = 2'd3;

  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 10'd512;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 10'd512;
  localparam logic [RAD_W-1:0] RST_RADIUS = 2'd1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

  typedef struct packed {
    logic accept;
    logic eval;
    logic ctr_rd;
    logic tap_init;
    logic tap_issue;
    logic tap_center;
    logic tap_row;
    logic cap_center;
    logic div_start;
    logic div_step;
    logic out_load;
  } bif_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              flush_idle;
    logic              ge_lag;
    logic [RAD_W-1:0]  radius;
    logic              out_free;
  } bif_sts_t;

endpackage

// File: rtl/bif_in_if.sv
interface bif_in_if import bif_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PIX_W-1:0]  pixel_in;
  logic [TIDX_W-1:0] table_index;
  logic [TVAL_W-1:0] table_value;

  modport source(output valid, output kind, output pixel_in, output table_index,
                 output table_value, input ready);
  modport sink(input valid, input kind, input pixel_in, input table_index,
               input table_value, output ready);
endinterface

// File: rtl/bif_out_if.sv
interface bif_out_if import bif_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_frame;

  modport source(output valid, output pixel_out, output last_of_frame, input ready);
  modport sink(input valid, input pixel_out, input last_of_frame, output ready);
endinterface

// File: rtl/bilateral_image_filter.sv
// Streaming bilateral filter for 8-bit grayscale frames. Words on in_if carry a
// pixel, a flush tick, or a load of one range or spatial weight table entry;
// both tables must be loaded before pixels that use them arrive. Each pixel,
// and each flush tick while a frame is in progress, takes one frame slot; once
// R*W+R slots past a center have been taken, that center's filtered value comes
// out on out_if, and flush ticks drain the last R*W+R outputs. For a slot that
// gives an output, the single line store read port visits one window tap per
// cycle, then a 9-step restoring divider forms the rounded quotient. A finished
// word waits in an output register while the next input word is taken. Writing
// image_width, image_height or radius restarts the frame.
module bilateral_image_filter import bif_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  bif_in_if.sink            in_if,
  bif_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);
  bif_cmd_t cmd;
  bif_sts_t sts;
  logic     in_ready;

  bif_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  bif_dp #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_kind(in_if.kind), .in_pixel(in_if.pixel_in),
    .in_tidx(in_if.table_index), .in_tval(in_if.table_value),
    .cmd(cmd), .sts(sts),
    .out_ready(out_if.ready), .out_valid(out_if.valid),
    .out_pixel(out_if.pixel_out), .out_last(out_if.last_of_frame)
  );

  assign in_if.ready = in_ready;
endmodule

// File: rtl/bif_ram.sv
module bif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/bif_ctrl.sv
module bif_ctrl import bif_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bif_sts_t sts,
  output bif_cmd_t cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_CTR   = 3'd2;
  localparam logic [2:0] S_TAPS  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUTW  = 3'd6;

  logic [2:0]       st_r, st_nxt;
  logic [TAP_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [TAP_W-1:0] rad, side_m1;

  assign rad     = TAP_W'(sts.radius);
  assign side_m1 = TAP_W'({sts.radius, 1'b0});

  always_comb begin
    st_nxt   = st_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    cnt_nxt  = cnt_r;
    cmd      = '0;
    in_ready = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          st_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.kind[1] && !sts.flush_idle && sts.ge_lag) begin
          st_nxt = S_CTR;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_CTR: begin
        cmd.ctr_rd   = 1'b1;
        cmd.tap_init = 1'b1;
        dx_nxt       = '0;
        dy_nxt       = '0;
        st_nxt       = S_TAPS;
      end
      S_TAPS: begin
        cmd.tap_issue  = 1'b1;
        cmd.cap_center = (dx_r == '0) && (dy_r == '0);
        cmd.tap_center = (dx_r == rad) && (dy_r == rad);
        cmd.tap_row    = (dx_r == side_m1);
        if (dx_r == side_m1) begin
          dx_nxt = '0;
          dy_nxt = dy_r + 1'b1;
          if (dy_r == side_m1) begin
            st_nxt  = S_DRAIN;
            cnt_nxt = '0;
          end
        end else begin
          dx_nxt = dx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'(PIPE_LAT - 1)) begin
          st_nxt  = S_DIV;
          cnt_nxt = '0;
        end
      end
      S_DIV: begin
        cmd.div_start = (cnt_r == '0);
        cmd.div_step  = (cnt_r != '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == 4'(QUO_BITS)) begin
          st_nxt = S_OUTW;
        end
      end
      S_OUTW: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      dx_r  <= '0;
      dy_r  <= '0;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

// File: rtl/bif_dp.sv
module bif_dp import bif_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic [TIDX_W-1:0] in_tidx,
  input  logic [TVAL_W-1:0] in_tval,
  input  bif_cmd_t          cmd,
  output bif_sts_t          sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [PIX_W-1:0]  out_pixel,
  output logic              out_last
);
  localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int AW       = $clog2(STORE_DEPTH);
  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int SP_DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int SAW      = $clog2(SP_DEPTH);
  localparam int RAW      = $clog2(RANGE_DEPTH);
  localparam int TW       = 2 * CFG_W;
  localparam int NW       = TW + 1;
  localparam int PW       = CFG_W + 2;
  localparam int WTW      = 2 * TVAL_W - WEIGHT_BITS;
  localparam int DENW     = WTW + $clog2(SP_DEPTH);
  localparam int NUMW     = DENW + PIX_W;
  localparam int NQW      = NUMW + 2;
  localparam logic [TVAL_W-1:0] WMASK =
    (WEIGHT_BITS >= TVAL_W) ? {TVAL_W{1'b1}} : TVAL_W'((1 << WEIGHT_BITS) - 1);

  function automatic logic [AW-1:0] mod_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] t;
    t = {1'b0, a} + (AW+1)'(STORE_DEPTH) - {1'b0, b};
    if (t >= (AW+1)'(STORE_DEPTH)) begin
      t = t - (AW+1)'(STORE_DEPTH);
    end
    return AW'(t);
  endfunction

  function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a,
                                            input logic signed [AW+1:0] d);
    logic signed [AW+1:0] t;
    t = signed'({2'b00, a}) + d;
    if (t < 0) begin
      t = t + (AW+2)'(STORE_DEPTH);
    end else if (t >= (AW+2)'(STORE_DEPTH)) begin
      t = t - (AW+2)'(STORE_DEPTH);
    end
    return AW'(t);
  endfunction

  // Configuration and derived frame geometry.
  logic [CFG_W-1:0] width_r, height_r;
  logic [RAD_W-1:0] radius_r;
  logic [CFG_W-1:0] w_cl, h_cl;
  logic [RAD_W-1:0] r_cl;
  logic [TW-1:0]    total_r, lag_r;
  logic             cfg_hit;

  assign w_cl = (width_r == '0) ? CFG_W'(1) :
                ((32'(width_r) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_r);
  assign h_cl = (height_r == '0) ? CFG_W'(1) :
                ((32'(height_r) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_r);
  assign r_cl = (radius_r == '0) ? RAD_W'(1) :
                ((32'(radius_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_r);
  assign cfg_hit = cfg_we && (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_RADIUS});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      radius_r <= RST_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    total_r <= TW'(w_cl) * TW'(h_cl);
    lag_r   <= TW'(r_cl) * TW'(w_cl) + TW'(r_cl);
  end

  // Latched input word.
  logic [KIND_W-1:0] kind_r;
  logic [PIX_W-1:0]  pix_r;
  logic [TIDX_W-1:0] tidx_r;
  logic [TVAL_W-1:0] tval_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      pix_r  <= in_pixel;
      tidx_r <= in_tidx;
      tval_r <= in_tval;
    end
  end

  // Frame position and center bookkeeping.
  logic [NW-1:0] n_r, c_lin;
  logic [AW-1:0] wp_r, wp_inc, c_addr_r, lag_a;
  logic [CFG_W-1:0] cx_r, cy_r;
  logic last_r, n_zero, ge_lag, last, flush_idle, ev_slot;

  assign n_zero     = (n_r == '0);
  assign ge_lag     = (n_r >= NW'(lag_r));
  assign c_lin      = n_r - NW'(lag_r);
  assign last       = ((c_lin + 1'b1) >= NW'(total_r));
  assign flush_idle = (kind_r == KIND_FLUSH) && n_zero;
  assign ev_slot    = cmd.eval && !kind_r[1] && !flush_idle;
  assign lag_a      = AW'(lag_r);
  assign wp_inc     = (wp_r == AW'(STORE_DEPTH - 1)) ? '0 : wp_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r  <= '0;
      wp_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_hit) begin
      n_r  <= '0;
      wp_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else begin
      if (ev_slot) begin
        if (ge_lag && last) begin
          n_r  <= '0;
          wp_r <= '0;
        end else begin
          n_r  <= n_r + 1'b1;
          wp_r <= wp_inc;
        end
      end
      if (cmd.div_start) begin
        if (last_r) begin
          cx_r <= '0;
          cy_r <= '0;
        end else if (cx_r + 1'b1 == w_cl) begin
          cx_r <= '0;
          cy_r <= cy_r + 1'b1;
        end else begin
          cx_r <= cx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_slot && ge_lag) begin
      c_addr_r <= mod_sub(wp_r, lag_a);
      last_r   <= last;
    end
  end

  // Memories.
  logic [PIX_W-1:0]  line_q, line_wdata;
  logic [AW-1:0]     line_raddr;
  logic              line_we, rng_we, sp_we;
  logic [TVAL_W-1:0] rng_q, sp_q;
  logic [RAW-1:0]    rng_raddr;
  logic [SAW-1:0]    sidx_r;

  assign line_we    = ev_slot && (n_r < NW'(total_r));
  assign line_wdata = (kind_r == KIND_PIXEL) ? pix_r : PIX_MIN;
  assign rng_we     = cmd.eval && (kind_r == KIND_RANGE);
  assign sp_we      = cmd.eval && (kind_r == KIND_SPATIAL) && (32'(tidx_r) < SP_DEPTH);

  bif_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_line (
    .clk(clk), .we(line_we), .waddr(wp_r), .wdata(line_wdata),
    .raddr(line_raddr), .rdata(line_q)
  );

  bif_ram #(.WIDTH(TVAL_W), .DEPTH(RANGE_DEPTH)) u_range (
    .clk(clk), .we(rng_we), .waddr(RAW'(tidx_r)), .wdata(tval_r & WMASK),
    .raddr(rng_raddr), .rdata(rng_q)
  );

  bif_ram #(.WIDTH(TVAL_W), .DEPTH(SP_DEPTH)) u_spatial (
    .clk(clk), .we(sp_we), .waddr(SAW'(tidx_r)), .wdata(tval_r & WMASK),
    .raddr(sidx_r), .rdata(sp_q)
  );

  // Tap walker: line store address and frame coordinates of the current tap.
  logic [AW-1:0]          taddr_r;
  logic signed [PW-1:0]   ty_r, tx_r, cx_s, cy_s, r_s, w_s, h_s;
  logic signed [AW+1:0]   row_delta;
  logic                   inb;

  assign cx_s      = signed'(PW'(cx_r));
  assign cy_s      = signed'(PW'(cy_r));
  assign r_s       = signed'(PW'(r_cl));
  assign w_s       = signed'(PW'(w_cl));
  assign h_s       = signed'(PW'(h_cl));
  assign row_delta = signed'((AW+2)'(w_cl)) - signed'((AW+2)'({r_cl, 1'b0}));
  assign inb       = (ty_r >= 0) && (ty_r < h_s) && (tx_r >= 0) && (tx_r < w_s);
  assign line_raddr = cmd.ctr_rd ? c_addr_r : taddr_r;

  always_ff @(posedge clk) begin
    if (cmd.tap_init) begin
      taddr_r <= mod_sub(c_addr_r, lag_a);
      ty_r    <= cy_s - r_s;
      tx_r    <= cx_s - r_s;
      sidx_r  <= '0;
    end else if (cmd.tap_issue) begin
      sidx_r <= sidx_r + 1'b1;
      if (cmd.tap_row) begin
        taddr_r <= mod_add(taddr_r, row_delta);
        ty_r    <= ty_r + 1'b1;
        tx_r    <= cx_s - r_s;
      end else begin
        taddr_r <= mod_add(taddr_r, (AW+2)'(1));
        tx_r    <= tx_r + 1'b1;
      end
    end
  end

  // Weight pipeline: pixel and range lookup, weight product, accumulate.
  logic               v1_r, v2_r, v3_r, inb1_r;
  logic [PIX_W-1:0]   center_r, p1, diff, p2_r, p3_r;
  logic [TVAL_W-1:0]  sp2_r;
  logic [2*TVAL_W-1:0] prod;
  logic [WTW-1:0]     wt3_r;
  logic [NUMW-1:0]    num_r;
  logic [DENW-1:0]    den_r;

  assign p1        = inb1_r ? line_q : PIX_MIN;
  assign diff      = (p1 > center_r) ? p1 - center_r : center_r - p1;
  assign rng_raddr = RAW'(diff);
  assign prod      = sp2_r * rng_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.tap_issue && !cmd.tap_center;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_center) begin
      center_r <= line_q;
    end
    inb1_r <= inb;
    p2_r   <= p1;
    sp2_r  <= sp_q;
    wt3_r  <= prod[2*TVAL_W-1:WEIGHT_BITS];
    p3_r   <= p2_r;
    if (cmd.tap_init) begin
      num_r <= '0;
      den_r <= '0;
    end else if (v3_r) begin
      num_r <= num_r + NUMW'(wt3_r) * NUMW'(p3_r);
      den_r <= den_r + DENW'(wt3_r);
    end
  end

  // Restoring divider, one quotient bit per cycle, for round(num / den).
  logic [NQW-1:0]      rem_r, dsh_r;
  logic [QUO_BITS-1:0] q_r;
  logic                dz_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= (NQW'(num_r) << 1) + NQW'(den_r);
      dsh_r <= NQW'(den_r) << QUO_BITS;
      q_r   <= '0;
      dz_r  <= (den_r == '0);
    end else if (cmd.div_step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[QUO_BITS-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QUO_BITS-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  // Output register.
  logic             out_valid_r, out_last_r;
  logic [PIX_W-1:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_r <= last_r;
      if (dz_r) begin
        out_pix_r <= center_r;
      end else if (q_r > QUO_BITS'(PIX_MAX)) begin
        out_pix_r <= PIX_MAX;
      end else begin
        out_pix_r <= q_r[PIX_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pix_r;
  assign out_last  = out_last_r;

  assign sts.kind       = kind_r;
  assign sts.flush_idle = flush_idle;
  assign sts.ge_lag     = ge_lag;
  assign sts.radius     = r_cl;
  assign sts.out_free   = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_div_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (!v1_r && !v2_r && !v3_r))
    else $error("divider started with taps still in the weight pipeline");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before its word was taken");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_slot && ge_lag && last && !cfg_hit) |=> (n_r == '0 && wp_r == '0))
    else $error("frame position not rewound after the last output pixel");
`endif
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bif_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int STORE_LEN  = 2 * DEF_MAX_RADIUS * DEF_MAX_WIDTH + 2 * DEF_MAX_RADIUS + 1;
  localparam int SPA_LEN    = (2 * DEF_MAX_RADIUS + 1) * (2 * DEF_MAX_RADIUS + 1);
  localparam int SPA_R1_LEN = 9;
  localparam int STALL_MAX  = 3000;
  localparam int DRAIN_WAIT = 100;
  localparam int RAND_ITEMS = 110;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0]  pix;
    logic [TIDX_W-1:0] idx;
    logic [TVAL_W-1:0] val;
    logic              typed;
    logic              has_out;
    logic [PIX_W-1:0]  opix;
    logic              olast;
  } word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } filt_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bif_in_if in_if();
  bif_out_if out_if();

  bilateral_image_filter i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the filter state.
  logic [CFG_W-1:0] sh_width;
  logic [CFG_W-1:0] sh_height;
  logic [RAD_W-1:0] sh_radius;
  logic [PIX_W-1:0] sh_store [STORE_LEN];
  logic [TVAL_W-1:0] sh_range [RANGE_DEPTH];
  logic [TVAL_W-1:0] sh_spatial [SPA_LEN];
  int unsigned sh_pos;

  filt_t filt_q [$];
  int mismatches;
  int words_checked;
  int items_sent;
  int phases_run;
  bit quiet;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int eff_width();
    return (sh_width == 0) ? 1 : ((sh_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(sh_width));
  endfunction

  function automatic int eff_height();
    return (sh_height == 0) ? 1 :
           ((sh_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(sh_height));
  endfunction

  function automatic int eff_radius();
    return (sh_radius == 0) ? 1 : int'(sh_radius);
  endfunction

  function automatic logic [PIX_W-1:0] bilateral_at(int c, int w, int h, int r);
    int cy, cx, y, x, p, ctr, diff, side, sidx;
    longint unsigned num, den, wt, q;
    cy = c / w;
    cx = c % w;
    side = 2 * r + 1;
    ctr = sh_store[c % STORE_LEN];
    num = 0;
    den = 0;
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        if (dy != 0 || dx != 0) begin
          y = cy + dy;
          x = cx + dx;
          p = 0;
          if (y >= 0 && y < h && x >= 0 && x < w) p = sh_store[(y * w + x) % STORE_LEN];
          diff = (p > ctr) ? p - ctr : ctr - p;
          sidx = (dy + r) * side + (dx + r);
          wt = (longint'(sh_spatial[sidx]) * longint'(sh_range[diff])) >> DEF_WEIGHT_BITS;
          num += wt * p;
          den += wt;
        end
      end
    end
    if (den == 0) return ctr[PIX_W-1:0];
    q = (2 * num + den) / (2 * den);
    if (q > PIX_MAX) q = PIX_MAX;
    return q[PIX_W-1:0];
  endfunction

  task automatic predict_filter(input word_t wd);
    int w, h, r, total, lag, n, c;
    filt_t e;
    if (wd.kind == KIND_RANGE) begin
      sh_range[wd.idx] = wd.val;
    end else if (wd.kind == KIND_SPATIAL) begin
      if (wd.idx < SPA_LEN) sh_spatial[wd.idx] = wd.val;
    end else begin
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      total = w * h;
      lag = r * w + r;
      n = sh_pos;
      if (!(wd.kind == KIND_FLUSH && n == 0)) begin
        if (n < total) sh_store[n % STORE_LEN] = (wd.kind == KIND_PIXEL) ? wd.pix : PIX_MIN;
        sh_pos = n + 1;
        if (n >= lag) begin
          c = n - lag;
          e.pix = bilateral_at(c, w, h, r);
          e.last = (c + 1 >= total);
          if (e.last) sh_pos = 0;
          filt_q.push_back(e);
        end
      end
    end
  endtask

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_word(input word_t wd);
    int depth;
    filt_t e;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= wd.kind;
    in_if.pixel_in <= wd.pix;
    in_if.table_index <= wd.idx;
    in_if.table_value <= wd.val;
    do @(posedge clk); while (!in_if.ready);
    depth = filt_q.size();
    predict_filter(wd);
    if (wd.typed) begin
      while (filt_q.size() > depth) void'(filt_q.pop_back());
      if (wd.has_out) begin
        e.pix = wd.opix;
        e.last = wd.olast;
        filt_q.push_back(e);
      end
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_WIDTH: sh_width = data;
      REG_HEIGHT: sh_height = data;
      REG_RADIUS: sh_radius = data[RAD_W-1:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) sh_pos = 0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] r);
    in_if.valid <= 1'b0;
    while (filt_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if ($urandom_range(0, 7) == 0) cfg_write(REG_UNUSED, CFG_W'($urandom));
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_RADIUS, r);
    cfg_we <= 1'b0;
    @(negedge clk);
    phases_run++;
  endtask

  function automatic word_t mk_word(logic [KIND_W-1:0] kind, logic [PIX_W-1:0] pix);
    word_t wd;
    wd = '0;
    wd.kind = kind;
    wd.pix = pix;
    wd.idx = TIDX_W'($urandom);
    wd.val = TVAL_W'($urandom);
    return wd;
  endfunction

  function automatic word_t rand_slot(int flush_pct);
    logic [PIX_W-1:0] p;
    case ($urandom_range(0, 9))
      0: p = PIX_MIN;
      1: p = PIX_MAX;
      default: p = PIX_W'($urandom);
    endcase
    if ($urandom_range(0, 99) < flush_pct) return mk_word(KIND_FLUSH, p);
    return mk_word(KIND_PIXEL, p);
  endfunction

  function automatic word_t rand_load();
    word_t wd;
    wd = mk_word(($urandom_range(0, 1) == 0) ? KIND_RANGE : KIND_SPATIAL, PIX_W'($urandom));
    if (wd.kind == KIND_SPATIAL) wd.idx = TIDX_W'($urandom_range(0, 63));
    return wd;
  endfunction

  // Output side: random ready bursts, always ready in the quiet tail.
  initial begin
    int left;
    out_if.ready = 1'b0;
    left = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_if.ready <= 1'b1;
      end else if (left > 0) begin
        left--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        left = $urandom_range(1, 8) - 1;
      end else begin
        out_if.ready <= 1'b1;
        left = $urandom_range(1, 16) - 1;
      end
    end
  end

  always @(posedge clk) begin
    filt_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      words_checked++;
      if (filt_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: pixel_out=%0d last_of_frame=%0b",
                   out_if.pixel_out, out_if.last_of_frame);
      end else begin
        e = filt_q.pop_front();
        if (out_if.pixel_out !== e.pix || out_if.last_of_frame !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pixel_out exp %0d got %0d, last_of_frame exp %0b got %0b",
                     e.pix, out_if.pixel_out, e.last, out_if.last_of_frame);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("watchdog: no word moved for %0d cycles", STALL_MAX);
        $display("bilateral_image_filter regression: fail");
        $finish;
      end
    end
  end

  initial begin
    word_t dir_rows [28];
    word_t wd;
    int w, h, r, total, lag, cut, random_start;

    in_if.valid = 1'b0;
    in_if.kind = KIND_PIXEL;
    in_if.pixel_in = '0;
    in_if.table_index = '0;
    in_if.table_value = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    rst_n = 1'b0;
    quiet = 1'b0;
    mismatches = 0;
    words_checked = 0;
    items_sent = 0;
    phases_run = 0;
    idle_cycles = 0;
    sh_width = RST_WIDTH;
    sh_height = RST_HEIGHT;
    sh_radius = RST_RADIUS;
    sh_pos = 0;
    foreach (sh_store[i]) sh_store[i] = '0;
    foreach (sh_range[i]) sh_range[i] = '0;
    foreach (sh_spatial[i]) sh_spatial[i] = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Range table random, the 3x3 spatial entries zero: every weight sum is zero,
    // so each output of the first frame is just its center pixel.
    for (int i = 0; i < RANGE_DEPTH; i++) begin
      wd = mk_word(KIND_RANGE, PIX_W'($urandom));
      wd.idx = TIDX_W'(i);
      send_word(wd);
    end
    for (int i = 0; i < SPA_R1_LEN; i++) begin
      wd = mk_word(KIND_SPATIAL, PIX_W'($urandom));
      wd.idx = TIDX_W'(i);
      wd.val = '0;
      send_word(wd);
    end
    configure(10'd3, 10'd2, 10'd1);

    dir_rows = '{
      '{KIND_PIXEL, 8'd0, 8'd0, 16'd0, 1'b1, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd255, 8'd0, 16'd0, 1'b1, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd7, 8'd0, 16'd0, 1'b1, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd128, 8'd0, 16'd0, 1'b1, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd1, 8'd0, 16'd0, 1'b1, 1'b1, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd254, 8'd0, 16'd0, 1'b1, 1'b1, 8'd255, 1'b0},
      '{KIND_FLUSH, 8'd0, 8'd0, 16'd0, 1'b1, 1'b1, 8'd7, 1'b0},
      // The frame is complete, so this pixel is dropped and acts as a flush tick.
      '{KIND_PIXEL, 8'd99, 8'd0, 16'd0, 1'b1, 1'b1, 8'd128, 1'b0},
      '{KIND_FLUSH, 8'd0, 8'd0, 16'd0, 1'b1, 1'b1, 8'd1, 1'b0},
      '{KIND_FLUSH, 8'd0, 8'd0, 16'd0, 1'b1, 1'b1, 8'd254, 1'b1},
      // No frame in progress: the tick is ignored.
      '{KIND_FLUSH, 8'd0, 8'd0, 16'd0, 1'b1, 1'b0, 8'd0, 1'b0},
      '{KIND_SPATIAL, 8'd0, 8'd200, 16'h1234, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_SPATIAL, 8'd0, 8'd49, 16'hFFFF, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_SPATIAL, 8'd0, 8'd48, 16'hFFFF, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_SPATIAL, 8'd0, 8'd0, 16'hFFFF, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_SPATIAL, 8'd0, 8'd1, 16'hFFFF, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_RANGE, 8'd0, 8'd255, 16'hFFFF, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_RANGE, 8'd0, 8'd0, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd255, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd255, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd255, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_FLUSH, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_PIXEL, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_FLUSH, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_FLUSH, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0},
      '{KIND_FLUSH, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0}
    };
    foreach (dir_rows[i]) send_word(dir_rows[i]);

    for (int i = 0; i < SPA_LEN; i++) begin
      wd = mk_word(KIND_SPATIAL, PIX_W'($urandom));
      wd.idx = TIDX_W'(i);
      send_word(wd);
    end

    random_start = items_sent;
    while (items_sent - random_start < RAND_ITEMS) begin
      if (items_sent - random_start > RAND_ITEMS * 4 / 5) quiet = 1'b1;
      case (phases_run)
        1: begin
          // Widest frame, abandoned partway through.
          configure(10'h3FF, 10'd1, 10'd1);
          for (int i = 0; i < 20; i++) send_word(rand_slot(5));
        end
        2: begin
          configure(10'd1, 10'h3FF, {8'hFF, 2'd3});
          for (int i = 0; i < 20; i++) send_word(rand_slot(10));
        end
        3: begin
          // All registers zero saturate to a 1x1 frame of radius 1.
          configure(10'd0, 10'd0, 10'd0);
          send_word(rand_slot(0));
          send_word(mk_word(KIND_FLUSH, PIX_W'($urandom)));
          send_word(mk_word(KIND_FLUSH, PIX_W'($urandom)));
        end
        default: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 6);
          r = $urandom_range(0, 3);
          configure(CFG_W'(w), CFG_W'(h), {8'($urandom_range(0, 255)), 2'(r)});
          r = eff_radius();
          total = w * h;
          lag = r * w + r;
          if ($urandom_range(0, 4) == 0) send_word(mk_word(KIND_FLUSH, PIX_W'($urandom)));
          cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, total + lag - 1) : total + lag;
          for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 29) == 0) send_word(rand_load());
            send_word(rand_slot(i < total ? 10 : 90));
          end
        end
      endcase
    end

    in_if.valid <= 1'b0;
    while (filt_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (filt_q.size() != 0) mismatches += filt_q.size();

    $display("Sent %0d words over %0d register settings; checked %0d filtered pixels.",
             items_sent, phases_run, words_checked);
    $display("Covered table loads, flush ticks, aborted frames and saturated sizes.");
    if (mismatches == 0) begin
      $display("bilateral_image_filter regression: pass");
    end else begin
      $display("bilateral_image_filter regression: fail");
    end
    $finish;
  end

endmodule
